>>> rtl/rlse_pkg.sv
// Shared types and constants for the RGB LED serial encoder.
`default_nettype none

package rlse_pkg;

  // Item kind carried on the input tuser
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  // Waveform phase, one-hot
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_ONE_HIGH  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ONE_LOW   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_HIGH = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ZERO_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_RESET_GAP = 3'd4;

  localparam int unsigned BitTicksW = 12;
  localparam int unsigned GapTicksW = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned ColorW    = 24;

  // Reset timings in ticks of 22 ns
  localparam logic [BitTicksW-1:0] ONE_HIGH_RST  = 12'd43;
  localparam logic [BitTicksW-1:0] ONE_LOW_RST   = 12'd1;
  localparam logic [BitTicksW-1:0] ZERO_HIGH_RST = 12'd1;
  localparam logic [BitTicksW-1:0] ZERO_LOW_RST  = 12'd22;
  localparam logic [GapTicksW-1:0] RESET_GAP_RST = 16'd2363;

  typedef struct packed {
    logic [BitTicksW-1:0] one_high;
    logic [BitTicksW-1:0] one_low;
    logic [BitTicksW-1:0] zero_high;
    logic [BitTicksW-1:0] zero_low;
    logic [GapTicksW-1:0] reset_gap;
  } cfg_t;

  // Result flags; line_level lands in bit 0
  typedef struct packed {
    logic rejected;
    logic frame_done;
    logic busy_res;
    logic line_level;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/rlse_cfg.sv
// Timing register file written through the plain configuration port.
`default_nettype none

module rlse_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rlse_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [rlse_pkg::CfgDataW-1:0]   cfg_data_i,
  output rlse_pkg::cfg_t                       cfg_o
);

  rlse_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        rlse_pkg::CFG_ONE_HIGH:  cfg_d.one_high  = cfg_data_i[rlse_pkg::BitTicksW-1:0];
        rlse_pkg::CFG_ONE_LOW:   cfg_d.one_low   = cfg_data_i[rlse_pkg::BitTicksW-1:0];
        rlse_pkg::CFG_ZERO_HIGH: cfg_d.zero_high = cfg_data_i[rlse_pkg::BitTicksW-1:0];
        rlse_pkg::CFG_ZERO_LOW:  cfg_d.zero_low  = cfg_data_i[rlse_pkg::BitTicksW-1:0];
        rlse_pkg::CFG_RESET_GAP: cfg_d.reset_gap = cfg_data_i[rlse_pkg::GapTicksW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high  <= rlse_pkg::ONE_HIGH_RST;
      cfg_q.one_low   <= rlse_pkg::ONE_LOW_RST;
      cfg_q.zero_high <= rlse_pkg::ZERO_HIGH_RST;
      cfg_q.zero_low  <= rlse_pkg::ZERO_LOW_RST;
      cfg_q.reset_gap <= rlse_pkg::RESET_GAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/rlse_core.sv
// Waveform state machine: one beat per cycle while step_i is high updates shifter, bit count and phase timer.
`default_nettype none

module rlse_core #(
  parameter int unsigned COLOR_BITS = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           step_i,
  input  wire rlse_pkg::op_e                  op_i,
  input  wire logic [rlse_pkg::ColorW-1:0]    color_i,
  input  wire rlse_pkg::cfg_t                 cfg_i,
  output rlse_pkg::res_t                      res_o
);

  localparam int unsigned BitsW = $clog2(COLOR_BITS + 1);
  localparam int unsigned TimerW = rlse_pkg::GapTicksW;
  localparam int unsigned ExtW = rlse_pkg::ColorW + 32;

  logic [COLOR_BITS-1:0] shift_q, shift_d;
  logic [BitsW-1:0]      bits_q, bits_d;
  rlse_pkg::phase_e      phase_q, phase_d;
  logic [TimerW-1:0]     timer_q, timer_d;

  logic [rlse_pkg::ColorW-1:0] grb;
  logic [ExtW-1:0]             grb_ext;
  logic [COLOR_BITS-1:0]       load_word;
  logic [COLOR_BITS-1:0]       shifted;
  logic [BitsW-1:0]            bits_dec;
  logic                        done, rej;

  // Swap red and green, then left align into the shifter width
  assign grb       = {color_i[15:8], color_i[23:16], color_i[7:0]};
  assign grb_ext   = {grb, 32'd0};
  assign load_word = grb_ext[ExtW-1 -: COLOR_BITS];
  assign shifted   = {shift_q[COLOR_BITS-2:0], 1'b0};
  assign bits_dec  = bits_q - BitsW'(1);

  // Next state for one beat
  always_comb begin
    shift_d = shift_q;
    bits_d  = bits_q;
    phase_d = phase_q;
    timer_d = timer_q;
    done    = 1'b0;
    rej     = 1'b0;
    if (op_i == rlse_pkg::OP_LOAD) begin
      if (phase_q != rlse_pkg::PH_IDLE) begin
        rej = 1'b1;
      end else begin
        shift_d = load_word;
        bits_d  = BitsW'(COLOR_BITS);
        phase_d = rlse_pkg::PH_HIGH;
        timer_d = load_word[COLOR_BITS-1] ? TimerW'(cfg_i.one_high)
                                          : TimerW'(cfg_i.zero_high);
      end
    end else if (phase_q != rlse_pkg::PH_IDLE) begin
      if (timer_q > TimerW'(1)) begin
        timer_d = timer_q - TimerW'(1);
      end else begin
        unique case (phase_q)
          rlse_pkg::PH_HIGH: begin
            phase_d = rlse_pkg::PH_LOW;
            timer_d = shift_q[COLOR_BITS-1] ? TimerW'(cfg_i.one_low)
                                            : TimerW'(cfg_i.zero_low);
          end
          rlse_pkg::PH_LOW: begin
            shift_d = shifted;
            bits_d  = bits_dec;
            if (bits_dec != '0) begin
              phase_d = rlse_pkg::PH_HIGH;
              timer_d = shifted[COLOR_BITS-1] ? TimerW'(cfg_i.one_high)
                                              : TimerW'(cfg_i.zero_high);
            end else begin
              phase_d = rlse_pkg::PH_GAP;
              timer_d = cfg_i.reset_gap;
            end
          end
          rlse_pkg::PH_GAP: begin
            phase_d = rlse_pkg::PH_IDLE;
            timer_d = '0;
            shift_d = '0;
            done    = 1'b1;
          end
          default: begin
            phase_d = rlse_pkg::PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      bits_q  <= '0;
      phase_q <= rlse_pkg::PH_IDLE;
      timer_q <= '0;
    end else if (step_i) begin
      shift_q <= shift_d;
      bits_q  <= bits_d;
      phase_q <= phase_d;
      timer_q <= timer_d;
    end
  end

  // Result of this beat
  assign res_o.line_level = (phase_d == rlse_pkg::PH_HIGH);
  assign res_o.busy_res   = (phase_d != rlse_pkg::PH_IDLE);
  assign res_o.frame_done = done;
  assign res_o.rejected   = rej;

endmodule

`default_nettype wire

>>> rtl/rgb_led_serial_encoder_top.sv
// Top level: input beat register, waveform core, result register, timing registers.
// An accepted beat waits in the input register; its result is registered in the result register when that can take it.
// Throughput: one beat per cycle while results are taken; the phase timer and shifter update once per beat.
// A stalled result beat holds the input register; input ready drops once one beat waits.
// Reset (async, active low): timing registers to defaults, line idle low, no beats held.
`default_nettype none

module rgb_led_serial_encoder_top #(
  parameter int unsigned COLOR_BITS = 24
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // tdata: color[23:0]
  input  wire logic [23:0]                    s_axis_tdata_i,
  // tuser: operation[0]
  input  wire logic                           s_axis_tuser_i,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: line_level[0], busy_res[1], frame_done[2], rejected[3], zero[7:4]
  output logic [7:0]                          m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [rlse_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rlse_pkg::CfgDataW-1:0]  cfg_data_i
);

  rlse_pkg::cfg_t cfg;
  rlse_pkg::res_t res;

  logic                        in_valid_q;
  rlse_pkg::op_e               op_q;
  logic [rlse_pkg::ColorW-1:0] color_q;
  logic                        out_valid_q;
  rlse_pkg::res_t              out_res_q;
  logic                        step;
  logic                        in_fire;

  // Beat moves from the input register when the result register can take it
  assign step            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || step;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  rlse_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rlse_core #(
    .COLOR_BITS (COLOR_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .op_i    (op_q),
    .color_i (color_q),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  // Input beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= rlse_pkg::op_e'(s_axis_tuser_i);
      color_q <= s_axis_tdata_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'd0, out_res_q};

endmodule

`default_nettype wire

>>> test/tb_rgb_led_serial_encoder_top.sv
// Self-checking testbench for the RGB LED serial encoder: directed table, then random frames.
`default_nettype none

module tb_rgb_led_serial_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COLOR_BITS = 24;
  // Cycles with no beat and no register write before the run is called hung
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandPhases = 4;
  localparam int unsigned PhaseBeats = 40;

  // Directed table row kinds
  typedef enum logic [1:0] {
    ROW_BEAT,
    ROW_CFG,
    ROW_FINISH
  } row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    rlse_pkg::op_e                   op;
    logic [rlse_pkg::ColorW-1:0]     color;
    bit                              fixed;
    rlse_pkg::res_t                  want;
    logic [rlse_pkg::CfgIdxW-1:0]    index;
    logic [rlse_pkg::CfgDataW-1:0]   value;
  } dir_row_t;

  // Result-side stall styles
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_TRICKLE
  } rx_mode_e;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic [rlse_pkg::ColorW-1:0]     s_axis_tdata_i = '0;
  logic                            s_axis_tuser_i = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [7:0]                      m_axis_tdata_o;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [rlse_pkg::CfgIdxW-1:0]    cfg_index_i = '0;
  logic [rlse_pkg::CfgDataW-1:0]   cfg_data_i = '0;

  rgb_led_serial_encoder_top #(
    .COLOR_BITS(COLOR_BITS)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Waveform predictor state and its copy of the timing registers
  rlse_pkg::cfg_t    timing;
  logic [31:0]       grb_shift = '0;    // bit being sent sits in bit 31
  int unsigned       bits_pending = 0;
  rlse_pkg::phase_e  wave_phase = rlse_pkg::PH_IDLE;
  logic [15:0]       ticks_left = '0;

  rlse_pkg::res_t    flag_q[$];         // predicted line status, oldest first
  dir_row_t          plan[$];
  int unsigned       mismatches = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left = 0;

  rx_mode_e          rx_mode = RX_OPEN;
  int unsigned       rx_mode_left = 0;
  logic [7:0]        rx_pattern = 8'h01;

  // High-phase length for the bit at the head of the shifter
  function automatic logic [15:0] high_len();
    return grb_shift[31] ? 16'(timing.one_high) : 16'(timing.zero_high);
  endfunction

  // Advance the predicted waveform by one input beat
  function automatic rlse_pkg::res_t step_waveform(input rlse_pkg::op_e op,
                                                   input logic [rlse_pkg::ColorW-1:0] rgb);
    rlse_pkg::res_t flags;
    logic [23:0] grb;
    flags = '0;
    if (op == rlse_pkg::OP_LOAD) begin
      if (wave_phase != rlse_pkg::PH_IDLE) begin
        flags.rejected = 1'b1;
      end else begin
        grb = {rgb[15:8], rgb[23:16], rgb[7:0]};
        grb_shift = {grb, 8'd0};
        bits_pending = COLOR_BITS;
        wave_phase = rlse_pkg::PH_HIGH;
        ticks_left = high_len();
      end
    end else if (wave_phase != rlse_pkg::PH_IDLE) begin
      // zero-length phases fall through here just like length one
      if (ticks_left > 16'd1) begin
        ticks_left = ticks_left - 16'd1;
      end else begin
        case (wave_phase)
          rlse_pkg::PH_HIGH: begin
            wave_phase = rlse_pkg::PH_LOW;
            ticks_left = grb_shift[31] ? 16'(timing.one_low) : 16'(timing.zero_low);
          end
          rlse_pkg::PH_LOW: begin
            grb_shift = grb_shift << 1;
            if (bits_pending > 0) bits_pending--;
            if (bits_pending != 0) begin
              wave_phase = rlse_pkg::PH_HIGH;
              ticks_left = high_len();
            end else begin
              wave_phase = rlse_pkg::PH_GAP;
              ticks_left = timing.reset_gap;
            end
          end
          default: begin
            wave_phase = rlse_pkg::PH_IDLE;
            ticks_left = '0;
            grb_shift = '0;
            flags.frame_done = 1'b1;
          end
        endcase
      end
    end
    flags.line_level = (wave_phase == rlse_pkg::PH_HIGH);
    flags.busy_res = (wave_phase != rlse_pkg::PH_IDLE);
    return flags;
  endfunction

  function automatic void add_beat(input rlse_pkg::op_e op,
                                   input logic [rlse_pkg::ColorW-1:0] color,
                                   input bit fixed, input rlse_pkg::res_t want);
    dir_row_t row;
    row.kind = ROW_BEAT;
    row.op = op;
    row.color = color;
    row.fixed = fixed;
    row.want = want;
    row.index = '0;
    row.value = '0;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [rlse_pkg::CfgIdxW-1:0] index,
                                  input logic [rlse_pkg::CfgDataW-1:0] value);
    dir_row_t row;
    row.kind = ROW_CFG;
    row.op = rlse_pkg::OP_TICK;
    row.color = '0;
    row.fixed = 1'b0;
    row.want = '0;
    row.index = index;
    row.value = value;
    plan.push_back(row);
  endfunction

  function automatic void add_finish();
    dir_row_t row;
    row.kind = ROW_FINISH;
    row.op = rlse_pkg::OP_TICK;
    row.color = '0;
    row.fixed = 1'b0;
    row.want = '0;
    row.index = '0;
    row.value = '0;
    plan.push_back(row);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one beat, with bursty gaps, and record its prediction on acceptance
  task automatic send_beat(input rlse_pkg::op_e op, input logic [rlse_pkg::ColorW-1:0] color,
                           input bit fixed, input rlse_pkg::res_t want);
    rlse_pkg::res_t model_flags;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= color;
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_flags = step_waveform(op, color);
    flag_q.push_back(fixed ? want : model_flags);
  endtask

  // Stop sending and wait for every predicted beat to come back
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (flag_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // One register write; the predictor copy follows at the same edge
  task automatic write_timing(input logic [rlse_pkg::CfgIdxW-1:0] index,
                              input logic [rlse_pkg::CfgDataW-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (index)
      rlse_pkg::CFG_ONE_HIGH:  timing.one_high = value[rlse_pkg::BitTicksW-1:0];
      rlse_pkg::CFG_ONE_LOW:   timing.one_low = value[rlse_pkg::BitTicksW-1:0];
      rlse_pkg::CFG_ZERO_HIGH: timing.zero_high = value[rlse_pkg::BitTicksW-1:0];
      rlse_pkg::CFG_ZERO_LOW:  timing.zero_low = value[rlse_pkg::BitTicksW-1:0];
      rlse_pkg::CFG_RESET_GAP: timing.reset_gap = value[rlse_pkg::GapTicksW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Result side: ready follows a randomly chosen stall style, picked anew when its run ends
  always @(posedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(16, 64);
      rx_pattern = 8'($urandom) | 8'h01;
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN: m_axis_tready_i <= 1'b1;
      RX_COIN: m_axis_tready_i <= 1'($urandom_range(0, 1));
      RX_PATTERN: begin
        m_axis_tready_i <= rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      end
      default: m_axis_tready_i <= (rx_mode_left[2:0] == 3'd0);
    endcase
  end

  // Result beat checker
  always @(posedge clk_i) begin : check_results
    rlse_pkg::res_t got;
    rlse_pkg::res_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[3:0];
      if (flag_q.size() == 0) begin
        report_mismatch("unexpected result beat", 32'(m_axis_tdata_o), '0);
      end else begin
        want = flag_q.pop_front();
        if (got.line_level !== want.line_level)
          report_mismatch("line_level", 32'(got.line_level), 32'(want.line_level));
        if (got.busy_res !== want.busy_res)
          report_mismatch("busy_res", 32'(got.busy_res), 32'(want.busy_res));
        if (got.frame_done !== want.frame_done)
          report_mismatch("frame_done", 32'(got.frame_done), 32'(want.frame_done));
        if (got.rejected !== want.rejected)
          report_mismatch("rejected", 32'(got.rejected), 32'(want.rejected));
      end
      if (m_axis_tdata_o[7:4] !== 4'd0)
        report_mismatch("tdata padding", 32'(m_axis_tdata_o[7:4]), '0);
    end
  end

  // Hang detector
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rlse_pkg::op_e op;
    int unsigned pause_at;
    timing = '{rlse_pkg::ONE_HIGH_RST, rlse_pkg::ONE_LOW_RST, rlse_pkg::ZERO_HIGH_RST,
               rlse_pkg::ZERO_LOW_RST, rlse_pkg::RESET_GAP_RST};

    // Directed rows; res_t literals read {rejected, frame_done, busy_res, line_level}
    // Tick while idle: nothing moves, color ignored
    add_beat(rlse_pkg::OP_TICK, 24'hFF_FFFF, 1'b1, 4'b0000);
    add_beat(rlse_pkg::OP_TICK, 24'h00_0000, 1'b1, 4'b0000);
    // Load drives the line high at once
    add_beat(rlse_pkg::OP_LOAD, 24'h00_FF00, 1'b1, 4'b0011);
    // Load while busy is dropped and flagged
    add_beat(rlse_pkg::OP_LOAD, 24'hFF_FFFF, 1'b1, 4'b1011);
    add_beat(rlse_pkg::OP_TICK, 24'h00_0000, 1'b0, '0);
    // Zero lengths written mid-frame act as one tick from the next phase on
    add_cfg(rlse_pkg::CFG_ZERO_HIGH, 16'd0);
    add_cfg(rlse_pkg::CFG_ZERO_LOW, 16'd0);
    add_cfg(rlse_pkg::CFG_RESET_GAP, 16'd1);
    // Bits above the 12-bit field are dropped
    add_cfg(rlse_pkg::CFG_ONE_HIGH, 16'hF002);
    add_finish();
    add_beat(rlse_pkg::OP_LOAD, 24'h00_0000, 1'b1, 4'b0011);
    add_beat(rlse_pkg::OP_TICK, 24'hFF_FFFF, 1'b0, '0);
    add_finish();
    // Red/green swap check
    add_beat(rlse_pkg::OP_LOAD, 24'h12_3456, 1'b0, '0);
    add_finish();
    // Upper data bits ignored on every short register
    add_cfg(rlse_pkg::CFG_ONE_HIGH, 16'hF003);
    add_cfg(rlse_pkg::CFG_ONE_LOW, 16'hF001);
    add_cfg(rlse_pkg::CFG_ZERO_HIGH, 16'hF002);
    add_cfg(rlse_pkg::CFG_ZERO_LOW, 16'hF001);
    add_cfg(rlse_pkg::CFG_RESET_GAP, 16'd5);
    add_beat(rlse_pkg::OP_LOAD, 24'h00_8000, 1'b1, 4'b0011);
    add_finish();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_BEAT: send_beat(plan[i].op, plan[i].color, plan[i].fixed, plan[i].want);
        ROW_CFG: begin
          drain_results();
          write_timing(plan[i].index, plan[i].value);
        end
        default: begin
          while (wave_phase != rlse_pkg::PH_IDLE)
            send_beat(rlse_pkg::OP_TICK, 24'($urandom), 1'b0, '0);
        end
      endcase
    end

    // Random frames under short random timings; rewrites may land mid-frame
    repeat (RandPhases) begin
      drain_results();
      write_timing(rlse_pkg::CFG_ONE_HIGH, 16'($urandom_range(1, 3)));
      write_timing(rlse_pkg::CFG_ONE_LOW, 16'($urandom_range(1, 3)));
      write_timing(rlse_pkg::CFG_ZERO_HIGH, 16'($urandom_range(1, 3)));
      write_timing(rlse_pkg::CFG_ZERO_LOW, 16'($urandom_range(1, 3)));
      write_timing(rlse_pkg::CFG_RESET_GAP, 16'($urandom_range(1, 6)));
      pause_at = $urandom_range(10, PhaseBeats - 5);
      for (int n = 0; n < PhaseBeats; n++) begin
        // hold off until the pipe is empty, usually mid-frame
        if (n == pause_at) drain_results();
        if (wave_phase == rlse_pkg::PH_IDLE)
          op = ($urandom_range(0, 9) < 7) ? rlse_pkg::OP_LOAD : rlse_pkg::OP_TICK;
        else
          op = ($urandom_range(0, 19) == 0) ? rlse_pkg::OP_LOAD : rlse_pkg::OP_TICK;
        send_beat(op, 24'($urandom), 1'b0, '0);
      end
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
